// ----- design/rrw_pkg.sv -----
// Shared types, register codes, step functions and sine table for the radial ripple warp.
package rrw_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_AMP     = 32763;
  localparam int QUARTER      = 256;
  localparam int HALF_TURN    = 512;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  localparam logic [2:0] REG_X_AMP  = 3'd0;
  localparam logic [2:0] REG_Y_AMP  = 3'd1;
  localparam logic [2:0] REG_FREQ   = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_EDGE   = 3'd5;
  localparam logic [2:0] REG_BG     = 3'd6;

  typedef struct packed {
    logic signed [7:0] x_amp;
    logic signed [7:0] y_amp;
    logic signed [7:0] freq;
    logic [8:0]        width;
    logic [8:0]        height;
    logic              edge_mode;
    logic [7:0]        bg;
  } cfg_t;

  // One classified item as it travels from the front through the queue and pipeline.
  typedef struct packed {
    logic              typ;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        pix;
    logic signed [9:0] dd;
    logic signed [9:0] ee;
    logic [7:0]        hw;
    logic [7:0]        hh;
    logic [8:0]        w;
    logic [8:0]        h;
  } item_t;

  typedef struct packed {
    logic [17:0] v;
    logic [17:0] res;
  } sq_t;

  typedef struct packed {
    logic       clamp;
    logic [8:0] m;
    logic [8:0] rem;
    logic [8:0] q;
  } div_t;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  // Three digit steps of the floor square root, top digit first.
  function automatic sq_t sq_step3(sq_t s, int top);
    sq_t         r;
    logic [18:0] t;
    logic [17:0] b;
    r = s;
    for (int i = 0; i < 3; i++) begin
      b = 18'(1) << (2 * (top - i));
      t = {1'b0, r.res} + {1'b0, b};
      if ({1'b0, r.v} >= t) begin
        r.v   = r.v - t[17:0];
        r.res = (r.res >> 1) + b;
      end else begin
        r.res = r.res >> 1;
      end
    end
    return r;
  endfunction

  // Three quotient bits of restoring division.
  function automatic div_t div_step3(div_t s);
    div_t       r;
    logic [9:0] t;
    r = s;
    for (int i = 0; i < 3; i++) begin
      t = {r.rem, 1'b0};
      if (t >= {1'b0, r.m}) begin
        r.rem = 9'(t - {1'b0, r.m});
        r.q   = {r.q[7:0], 1'b1};
      end else begin
        r.rem = t[8:0];
        r.q   = {r.q[7:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic sine_tab_t sine_table();
    sine_tab_t tab;
    int        q;
    int        k;
    int        v;
    real       ang;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      q = i % HALF_TURN;
      k = (q <= QUARTER) ? q : HALF_TURN - q;
      if (k == 0) begin
        v = 0;
      end else if (k >= QUARTER) begin
        v = SINE_AMP;
      end else begin
        ang = 3.14159265358979323846 * real'(k) / 512.0;
        v = $rtoi(real'(SINE_AMP) * $sin(ang));
      end
      tab[i] = ((i / HALF_TURN) % 2 == 1) ? 16'(-v) : 16'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = sine_table();

endpackage

// ----- design/rrw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rrw_front.sv -----
// Front end: classify incoming items, drop stray loads, work out sizes and center offsets.
module rrw_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  rrw_pkg::cfg_t  cfg,
  input  logic           req_type,
  input  logic [7:0]     x_pos,
  input  logic [7:0]     y_pos,
  input  logic [7:0]     pixel_in,
  output logic           keep,
  output rrw_pkg::item_t item
);

  logic [8:0] w;
  logic [8:0] h;

  // saturate to 2..MAX and force even
  always_comb begin
    w = cfg.width;
    if (w < 9'd2) w = 9'd2;
    if (32'(w) > MAX_WIDTH) w = 9'(MAX_WIDTH);
    w[0] = 1'b0;
    h = cfg.height;
    if (h < 9'd2) h = 9'd2;
    if (32'(h) > MAX_HEIGHT) h = 9'(MAX_HEIGHT);
    h[0] = 1'b0;
  end

  always_comb begin
    item.typ = req_type;
    item.x   = x_pos;
    item.y   = y_pos;
    item.pix = pixel_in;
    item.w   = w;
    item.h   = h;
    item.hw  = w[8:1];
    item.hh  = h[8:1];
    item.dd  = $signed({2'b0, w[8:1]}) - 10'sd1 - $signed({2'b0, x_pos});
    item.ee  = $signed({2'b0, h[8:1]}) - 10'sd1 - $signed({2'b0, y_pos});
  end

  // drop loads that land outside the store
  assign keep = (req_type == rrw_pkg::REQ_RENDER) ||
                ((32'(x_pos) < MAX_WIDTH) && (32'(y_pos) < MAX_HEIGHT));

endmodule

// ----- design/rrw_queue.sv -----
// Short item queue between front and back ends.
module rrw_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrw_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output rrw_pkg::item_t head
);

  localparam int PW = $clog2(DEPTH);

  rrw_pkg::item_t      slots [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- design/rrw_back.sv -----
// Back end: ring, phase and offset pipeline, image store access and output register.
module rrw_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  rrw_pkg::cfg_t  cfg,
  input  logic           q_nonempty,
  input  rrw_pkg::item_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     pixel_out,
  output logic [7:0]     src_x,
  output logic [7:0]     src_y,
  output logic           outside
);

  localparam int NST = 14;
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic           en;
  logic           vld [NST];
  rrw_pkg::item_t it  [NST];

  logic [17:0]        dsq, esq, wsq, hsq;
  rrw_pkg::sq_t       sq_a [2:5];
  rrw_pkg::sq_t       sq_m [2:5];
  rrw_pkg::div_t      dv   [6:9];
  logic [9:0]         phase;
  logic signed [15:0] sn, cs;
  logic signed [23:0] py, px;
  logic signed [9:0]  sx, sy;

  logic        out_vld;
  logic        out_out;
  logic [7:0]  out_bg;
  logic [7:0]  ram_q;

  // advance the whole pipe unless a finished result is still waiting
  assign en    = !out_vld || out_ready;
  assign q_pop = q_nonempty && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= q_pop;
      for (int k = 1; k < NST; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0] <= q_head;
      for (int k = 1; k < NST; k++) it[k] <= it[k-1];
    end
  end

  // squares, sums, root digits
  logic signed [19:0] dd2, ee2;
  logic [8:0]         root_a, root_m;
  logic [17:0]        prod_r;
  logic [8:0]         r;
  logic signed [17:0] pf;

  assign dd2    = it[0].dd * it[0].dd;
  assign ee2    = it[0].ee * it[0].ee;
  assign root_a = sq_a[5].res[8:0];
  assign root_m = sq_m[5].res[8:0];
  assign r      = dv[9].clamp ? 9'd511 : dv[9].q;
  assign pf     = $signed({1'b0, r}) * cfg.freq;
  assign prod_r = pf;

  always_ff @(posedge clk) begin
    if (en) begin
      dsq <= dd2[17:0];
      esq <= ee2[17:0];
      wsq <= {2'b0, 16'(it[0].hw) * 16'(it[0].hw)};
      hsq <= {2'b0, 16'(it[0].hh) * 16'(it[0].hh)};
      sq_a[2] <= '{v: dsq + esq, res: '0};
      sq_m[2] <= '{v: wsq + hsq, res: '0};
      sq_a[3] <= rrw_pkg::sq_step3(sq_a[2], 8);
      sq_m[3] <= rrw_pkg::sq_step3(sq_m[2], 8);
      sq_a[4] <= rrw_pkg::sq_step3(sq_a[3], 5);
      sq_m[4] <= rrw_pkg::sq_step3(sq_m[3], 5);
      sq_a[5] <= rrw_pkg::sq_step3(sq_a[4], 2);
      sq_m[5] <= rrw_pkg::sq_step3(sq_m[4], 2);
      // ring at or beyond the radius saturates
      dv[6] <= '{clamp: (root_a >= root_m), m: root_m,
                 rem: (root_a >= root_m) ? 9'd0 : root_a, q: '0};
      dv[7] <= rrw_pkg::div_step3(dv[6]);
      dv[8] <= rrw_pkg::div_step3(dv[7]);
      dv[9] <= rrw_pkg::div_step3(dv[8]);
      phase <= prod_r[12:3];
      sn    <= rrw_pkg::SINE_TABLE[phase];
      cs    <= rrw_pkg::SINE_TABLE[10'(phase + 10'd256)];
      py    <= sn * cfg.y_amp;
      px    <= cs * cfg.x_amp;
      sx    <= $signed({2'b0, it[12].x}) - $signed({px[23], px[23:15]});
      sy    <= $signed({2'b0, it[12].y}) - $signed({py[23], py[23:15]});
    end
  end

  // bounds, clamp and store access
  logic             ox_out, oy_out, bg_sel;
  logic [8:0]       cx, cy, ax, ay;
  logic [AW-1:0]    addr;
  logic             ram_we, ram_re;
  logic signed [9:0] wlim, hlim;

  always_comb begin
    wlim   = $signed({1'b0, it[13].w});
    hlim   = $signed({1'b0, it[13].h});
    ox_out = (sx < 10'sd0) || (sx >= wlim);
    oy_out = (sy < 10'sd0) || (sy >= hlim);
    bg_sel = cfg.edge_mode && (ox_out || oy_out);
    if (sx < 10'sd0)      cx = 9'd0;
    else if (sx >= wlim)  cx = it[13].w - 9'd1;
    else                  cx = sx[8:0];
    if (sy < 10'sd0)      cy = 9'd0;
    else if (sy >= hlim)  cy = it[13].h - 9'd1;
    else                  cy = sy[8:0];
    if (it[13].typ == rrw_pkg::REQ_LOAD) begin
      ax = {1'b0, it[13].x};
      ay = {1'b0, it[13].y};
    end else begin
      ax = cx;
      ay = cy;
    end
    addr = AW'(32'(ay) * MAX_WIDTH + 32'(ax));
  end

  assign ram_we = en && vld[13] && (it[13].typ == rrw_pkg::REQ_LOAD);
  assign ram_re = en && vld[13] && (it[13].typ == rrw_pkg::REQ_RENDER);

  rrw_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (it[13].pix),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[13] && (it[13].typ == rrw_pkg::REQ_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_out <= bg_sel;
      out_bg  <= cfg.bg;
      src_x   <= bg_sel ? 8'd0 : cx[7:0];
      src_y   <= bg_sel ? 8'd0 : cy[7:0];
    end
  end

  assign out_valid = out_vld;
  assign outside   = out_out;
  assign pixel_out = out_out ? out_bg : ram_q;

  a_render_yields: assert property (@(posedge clk) disable iff (rst)
    (en && vld[13] && it[13].typ == rrw_pkg::REQ_RENDER) |=> out_vld)
    else $error("render at store stage gave no result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (en && vld[13] && it[13].typ == rrw_pkg::REQ_LOAD) |=> !out_vld)
    else $error("load produced a result");

  a_bg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_out) |-> (src_x == 8'd0 && src_y == 8'd0 && cfg.edge_mode))
    else $error("background result with nonzero source place");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (sq_a[5].res[17:9] == '0 && sq_m[5].res[17:9] == '0))
    else $error("square root out of range");

endmodule

// ----- design/radial_ripple_image_warp_unit.sv -----
// Top level of the radial ripple image warp: config registers, front end, queue, back end.
//
//   channel  | signals                                      | direction
//   ---------+----------------------------------------------+----------
//   input    | in_valid/in_ready, req_type x_pos y_pos pixel_in | in
//   result   | out_valid/out_ready, pixel_out src_x src_y outside | out
//   config   | cfg_write, cfg_index, cfg_data               | in
//
// One item per cycle while out_ready is high; loads and renders share the same slot rate.
// A render result passes through the queue, then the 14-stage back pipeline (squares,
// sums, 3-stage square roots side by side, 3-stage ring divider, phase, sine read,
// amplitude multiply, offset), then the image store read, which shares its edge with
// the output register.
// Reset (rst, synchronous) empties queue and pipeline and loads register defaults;
// the image store is not cleared.
// A result held by out_ready low freezes the back pipeline; the 4-entry queue keeps
// in_ready high until it fills.
module radial_ripple_image_warp_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] x_pos,
  input  logic [7:0] y_pos,
  input  logic [7:0] pixel_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_out,
  output logic [7:0] src_x,
  output logic [7:0] src_y,
  output logic       outside
);

  rrw_pkg::cfg_t  cfg;
  rrw_pkg::item_t f_item;
  rrw_pkg::item_t q_head;
  logic           f_keep;
  logic           q_full;
  logic           q_nonempty;
  logic           q_pop;
  logic           push;

  // register file; write only while no item is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_amp     <= '0;
      cfg.y_amp     <= '0;
      cfg.freq      <= '0;
      cfg.width     <= 9'd256;
      cfg.height    <= 9'd256;
      cfg.edge_mode <= 1'b0;
      cfg.bg        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rrw_pkg::REG_X_AMP:  cfg.x_amp     <= cfg_data[7:0];
        rrw_pkg::REG_Y_AMP:  cfg.y_amp     <= cfg_data[7:0];
        rrw_pkg::REG_FREQ:   cfg.freq      <= cfg_data[7:0];
        rrw_pkg::REG_WIDTH:  cfg.width     <= cfg_data;
        rrw_pkg::REG_HEIGHT: cfg.height    <= cfg_data;
        rrw_pkg::REG_EDGE:   cfg.edge_mode <= cfg_data[0];
        rrw_pkg::REG_BG:     cfg.bg        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // accept whenever the queue has room; dropped loads still count as accepted
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && f_keep;

  rrw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .cfg      (cfg),
    .req_type (req_type),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .pixel_in (pixel_in),
    .keep     (f_keep),
    .item     (f_item)
  );

  rrw_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  rrw_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .src_x      (src_x),
    .src_y      (src_y),
    .outside    (outside)
  );

endmodule
